// ----- hw/rtl/pav_pkg.sv -----
// Shared types and constants of the path allowlist validator
`default_nettype none

package pav_pkg;

	// input item: one path byte and the end-of-path flag
	typedef struct packed {
		logic [7:0] ch;
		logic       last;
	} pav_in_t;

	// result item: verdict and the root that matched
	typedef struct packed {
		logic [1:0] verdict;
		logic [1:0] matched_root;
	} pav_out_t;

	// verdict codes
	localparam logic [1:0] VERDICT_WRITABLE  = 2'd0;
	localparam logic [1:0] VERDICT_MALFORMED = 2'd1;
	localparam logic [1:0] VERDICT_OUTSIDE   = 2'd2;

	// root codes
	localparam logic [1:0] ROOT_COMPANION = 2'd0;
	localparam logic [1:0] ROOT_SLEEP     = 2'd1;
	localparam logic [1:0] ROOT_BRAIN     = 2'd2;
	localparam logic [1:0] ROOT_NONE      = 2'd3;

	localparam int ROOT_COUNT = 3;
	localparam int ROOT_CHARS = 12;

	// root prefixes, lower case, zero padded
	localparam logic [0:ROOT_COUNT-1][0:ROOT_CHARS-1][7:0] ROOT_TEXT = {
		"/.companion/",
		"/.sleep/", 32'h0,
		"/brain/", 40'h0
	};
	localparam logic [0:ROOT_COUNT-1][3:0] ROOT_LEN = {4'd12, 4'd8, 4'd7};

	// characters of interest
	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_DOT    = 8'h2E;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_NUL    = 8'h00;
	localparam logic [7:0] CH_UPPER_A = 8'h41;
	localparam logic [7:0] CH_UPPER_Z = 8'h5A;

	// counters and register defaults
	localparam int         CNT_W       = 11;
	localparam logic [CNT_W-1:0] CNT_MAX = 11'd2047;
	localparam int         MAXLEN_W    = 10;
	localparam logic [MAXLEN_W-1:0] MAXLEN_RESET = 10'd255;
	localparam logic [1:0] SEG_SAT     = 2'd3;

endpackage

`default_nettype wire

// ----- hw/rtl/path_allowlist_validator_unit.sv -----
// Top level of the path allowlist validator
`default_nettype none

// Path allowlist validator. A path streams in one byte per item, the last
// byte flagged by last; on that byte one result item comes out with the
// verdict (writable, malformed, outside the roots) and the matched root.
// Other bytes give no result. One item is taken every cycle while in_stall
// is low. An item passes an input register and then the check logic into
// the result register. in_stall rises only while both the input register
// and the result register are full and out_stall is high. cfg_wdata sets
// the longest accepted path; write it only while no path is in flight.
module path_allowlist_validator_unit
	import pav_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output      logic                in_stall,
	input  wire pav_in_t             in_data,
	output      logic                out_valid,
	input  wire logic                out_stall,
	output      pav_out_t            out_data,
	input  wire logic                cfg_we,
	input  wire logic [MAXLEN_W-1:0] cfg_wdata
);

	logic                valid_s1;
	pav_in_t             in_s1;
	logic                res_valid_q;
	pav_out_t            res_q;
	logic [MAXLEN_W-1:0] max_len_q;

	logic [CNT_W-1:0]    count_q;
	logic [1:0]          seg_len_q;
	logic                seg_dots_q;
	logic                bad_q;
	logic [ROOT_COUNT-1:0] root_ok_q;

	logic                advance;
	logic                in_take;

	logic [7:0]          lower;
	logic [CNT_W-1:0]    count_nx;
	logic [1:0]          seg_len_nx;
	logic                seg_dots_nx;
	logic                bad_nx;
	logic [ROOT_COUNT-1:0] root_ok_nx;
	logic                bad_final;
	logic [1:0]          root_sel;
	pav_out_t            res_nx;

	// handshake
	assign advance   = valid_s1 && (!res_valid_q || !out_stall);
	assign in_stall  = valid_s1 && res_valid_q && out_stall;
	assign in_take   = in_valid && !in_stall;
	assign out_valid = res_valid_q;
	assign out_data  = res_q;

	// limit register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_len_q <= MAXLEN_RESET;
		end else if (cfg_we) begin
			max_len_q <= cfg_wdata;
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			in_s1 <= in_data;
		end
	end

	// per-byte checks and state update
	always_comb begin
		lower = in_s1.ch;
		if (in_s1.ch >= CH_UPPER_A && in_s1.ch <= CH_UPPER_Z) begin
			lower = in_s1.ch + 8'd32;
		end

		bad_nx = bad_q || in_s1.ch == CH_NUL || in_s1.ch == CH_BSLASH;

		// root prefix tracking
		root_ok_nx = root_ok_q;
		for (int r = 0; r < ROOT_COUNT; r++) begin
			if (count_q < {{(CNT_W-4){1'b0}}, ROOT_LEN[r]} &&
			    lower != ROOT_TEXT[r][count_q[3:0]]) begin
				root_ok_nx[r] = 1'b0;
			end
		end

		// segment tracking
		seg_len_nx  = seg_len_q;
		seg_dots_nx = seg_dots_q;
		if (count_q == '0) begin
			if (in_s1.ch != CH_SLASH) begin
				bad_nx = 1'b1;
			end
		end else if (in_s1.ch == CH_SLASH) begin
			if (seg_len_q == 2'd0 || (seg_len_q <= 2'd2 && seg_dots_q)) begin
				bad_nx = 1'b1;
			end
			seg_len_nx  = 2'd0;
			seg_dots_nx = 1'b1;
		end else begin
			if (seg_len_q != SEG_SAT) begin
				seg_len_nx = seg_len_q + 2'd1;
			end
			if (in_s1.ch != CH_DOT) begin
				seg_dots_nx = 1'b0;
			end
		end

		count_nx = (count_q == CNT_MAX) ? count_q : count_q + 11'd1;

		// final checks on the closing byte
		bad_final = bad_nx || seg_len_nx == 2'd0 ||
			(seg_len_nx <= 2'd2 && seg_dots_nx) ||
			count_nx < 11'd2 || count_nx > {1'b0, max_len_q} ||
			in_s1.ch == CH_SLASH;

		// first matching root with a leaf after it
		priority if (root_ok_nx[0] && count_nx > {{(CNT_W-4){1'b0}}, ROOT_LEN[0]}) begin
			root_sel = ROOT_COMPANION;
		end else if (root_ok_nx[1] && count_nx > {{(CNT_W-4){1'b0}}, ROOT_LEN[1]}) begin
			root_sel = ROOT_SLEEP;
		end else if (root_ok_nx[2] && count_nx > {{(CNT_W-4){1'b0}}, ROOT_LEN[2]}) begin
			root_sel = ROOT_BRAIN;
		end else begin
			root_sel = ROOT_NONE;
		end

		if (bad_final) begin
			res_nx.verdict      = VERDICT_MALFORMED;
			res_nx.matched_root = ROOT_NONE;
		end else if (root_sel == ROOT_NONE) begin
			res_nx.verdict      = VERDICT_OUTSIDE;
			res_nx.matched_root = ROOT_NONE;
		end else begin
			res_nx.verdict      = VERDICT_WRITABLE;
			res_nx.matched_root = root_sel;
		end
	end

	// path state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			seg_len_q  <= 2'd0;
			seg_dots_q <= 1'b1;
			bad_q      <= 1'b0;
			root_ok_q  <= '1;
		end else if (advance) begin
			if (in_s1.last) begin
				count_q    <= '0;
				seg_len_q  <= 2'd0;
				seg_dots_q <= 1'b1;
				bad_q      <= 1'b0;
				root_ok_q  <= '1;
			end else begin
				count_q    <= count_nx;
				seg_len_q  <= seg_len_nx;
				seg_dots_q <= seg_dots_nx;
				bad_q      <= bad_nx;
				root_ok_q  <= root_ok_nx;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance && in_s1.last) begin
			res_valid_q <= 1'b1;
		end else if (!out_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && in_s1.last) begin
			res_q <= res_nx;
		end
	end

endmodule

`default_nettype wire

// ----- hw/rtl/pav_checker.sv -----
// Port checker of the path allowlist validator and its bind
`default_nettype none

module pav_checker
	import pav_pkg::*;
(
	input wire logic                clk,
	input wire logic                arst_n,
	input wire logic                in_valid,
	input wire logic                in_stall,
	input wire pav_in_t             in_data,
	input wire logic                out_valid,
	input wire logic                out_stall,
	input wire pav_out_t            out_data
);

	// input backs up only behind a held result
	assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled without a held result");

	// a stalled input item stays put
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_stall |=> in_valid && $stable(in_data))
		else $error("stalled input item changed");

	// a held result stays put
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("held result changed");

	// only a writable verdict names a root
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.verdict != VERDICT_WRITABLE |->
			out_data.matched_root == ROOT_NONE)
		else $error("root given with a rejecting verdict");

	// writable verdict always names a root
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.verdict == VERDICT_WRITABLE |->
			out_data.matched_root != ROOT_NONE)
		else $error("writable verdict without a root");

endmodule

bind path_allowlist_validator_unit pav_checker u_pav_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.in_data   (in_data),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_data  (out_data)
);

`default_nettype wire
